// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lexer RTL; they expand to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CEL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define CEL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define CEL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define CEL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/cel_pkg.sv =====
// Shared types and default sizes for the expression lexer.
package cel_pkg;

  localparam int INT_BITS_DEF        = 32;
  localparam int FRAC_BITS_DEF       = 24;
  localparam int MAX_FRAC_DIGITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 4;

  typedef enum logic [3:0] {
    TK_UNKNOWN = 4'd0,
    TK_PLUS    = 4'd1,
    TK_MINUS   = 4'd2,
    TK_DIVIDE  = 4'd3,
    TK_TIMES   = 4'd4,
    TK_POWER   = 4'd5,
    TK_MOD     = 4'd6,
    TK_SIN     = 4'd7,
    TK_COS     = 4'd8,
    TK_TAN     = 4'd9,
    TK_LPAREN  = 4'd10,
    TK_RPAREN  = 4'd11,
    TK_NUMBER  = 4'd12,
    TK_END     = 4'd13
  } tok_kind_t;

  // One queue entry carries one or two tokens; only the first may be a number.
  typedef struct packed {
    logic      two;
    tok_kind_t k0;
    tok_kind_t k1;
    logic      ov;
  } tok_ctl_t;

endpackage

// ===== rtl/core/cel_if.sv =====
// Channel interfaces: character input and token output.
interface cel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface cel_out_if #(
  parameter int INT_BITS      = cel_pkg::INT_BITS_DEF,
  parameter int FRACTION_BITS = cel_pkg::FRAC_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [INT_BITS-1:0]      int_part;
  logic [FRACTION_BITS-1:0] frac_part;
  logic                     overflowed;
  logic                     last_of_run;
  modport source (output valid, output token_kind, output int_part, output frac_part,
                  output overflowed, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_part, input frac_part,
                  input overflowed, input last_of_run, output ready);
endinterface

// ===== rtl/core/cel_front.sv =====
// Front end: scans a character a cycle unless q_full, queues finished tokens.
`include "assert_macros.svh"
module cel_front #(
  parameter int INT_BITS            = cel_pkg::INT_BITS_DEF,
  parameter int FRACTION_BITS       = cel_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = cel_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  cel_in_if.sink                   in_ch,
  input  logic                     q_full,
  output logic                     push,
  output cel_pkg::tok_ctl_t        push_ctl,
  output logic [INT_BITS-1:0]      push_int,
  output logic [FRACTION_BITS-1:0] push_frac
);
  import cel_pkg::*;

  typedef enum logic [8:0] {
    M_IDLE = 9'b000000001,
    M_INT  = 9'b000000010,
    M_FRAC = 9'b000000100,
    M_S    = 9'b000001000,
    M_SI   = 9'b000010000,
    M_C    = 9'b000100000,
    M_CO   = 9'b001000000,
    M_T    = 9'b010000000,
    M_TA   = 9'b100000000
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam int          IW   = INT_BITS + 4;
  localparam logic [63:0] FULL = 64'd1 << FRACTION_BITS;
  // Fraction digit weights, floor(2^FRACTION_BITS / 10^k).
  localparam logic [FRACTION_BITS-1:0] W1 = FRACTION_BITS'(FULL / 64'd10);
  localparam logic [FRACTION_BITS-1:0] W2 = FRACTION_BITS'(FULL / 64'd100);
  localparam logic [FRACTION_BITS-1:0] W3 = FRACTION_BITS'(FULL / 64'd1000);
  localparam logic [FRACTION_BITS-1:0] W4 = FRACTION_BITS'(FULL / 64'd10000);
  localparam logic [FRACTION_BITS-1:0] W5 = FRACTION_BITS'(FULL / 64'd100000);
  localparam logic [FRACTION_BITS-1:0] W6 = FRACTION_BITS'(FULL / 64'd1000000);
  localparam logic [FRACTION_BITS-1:0] W7 = FRACTION_BITS'(FULL / 64'd10000000);
  localparam logic [FRACTION_BITS-1:0] W8 = FRACTION_BITS'(FULL / 64'd100000000);
  localparam logic [FRACTION_BITS-1:0] W9 = FRACTION_BITS'(FULL / 64'd1000000000);
  localparam logic [3:0] FRAC_LIMIT = 4'(MAX_FRACTION_DIGITS);

  mode_t                    mode_r, mode_nxt;
  logic [INT_BITS-1:0]      int_r, int_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic [3:0]               cnt_r, cnt_nxt;
  logic                     ov_r, ov_nxt;

  logic [7:0]               c;
  logic [7:0]               c_off;
  logic [3:0]               d;
  logic                     is_dig;
  logic                     accept;
  logic [IW-1:0]            prod;
  logic                     sat;
  logic [3:0]               cnt_inc;
  logic [FRACTION_BITS-1:0] wsel;
  logic [FRACTION_BITS+3:0] fprod;
  logic [FRACTION_BITS-1:0] frac_sum;

  logic      consumed;
  logic      a_vld, b_vld, a_num;
  tok_kind_t a_kind, b_kind;
  logic      kw, kw_fin;
  logic [7:0] kw_want;
  mode_t     kw_next;
  tok_kind_t kw_kind;

  assign c        = in_ch.char_code;
  assign c_off    = c - CH_0;
  assign d        = c_off[3:0];
  assign is_dig   = c inside {[CH_0:CH_9]};
  assign in_ch.ready = !q_full;
  assign accept   = in_ch.valid && !q_full;

  assign prod    = IW'(int_r) * IW'(10) + IW'(d);
  assign sat     = prod[IW-1:INT_BITS] != 4'd0;
  assign cnt_inc = cnt_r + 4'd1;

  always_comb begin
    case (cnt_inc)
      4'd1:    wsel = W1;
      4'd2:    wsel = W2;
      4'd3:    wsel = W3;
      4'd4:    wsel = W4;
      4'd5:    wsel = W5;
      4'd6:    wsel = W6;
      4'd7:    wsel = W7;
      4'd8:    wsel = W8;
      4'd9:    wsel = W9;
      default: wsel = '0;
    endcase
  end

  assign fprod    = (FRACTION_BITS+4)'(wsel) * (FRACTION_BITS+4)'(d);
  assign frac_sum = frac_r + fprod[FRACTION_BITS-1:0];

  // Keyword progress table for the partial-keyword modes.
  always_comb begin
    kw      = 1'b1;
    kw_want = CH_I;
    kw_next = M_IDLE;
    kw_fin  = 1'b0;
    kw_kind = TK_UNKNOWN;
    case (mode_r)
      M_S: begin
        kw_want = CH_I;
        kw_next = M_SI;
      end
      M_SI: begin
        kw_want = CH_N;
        kw_fin  = 1'b1;
        kw_kind = TK_SIN;
      end
      M_C: begin
        kw_want = CH_O;
        kw_next = M_CO;
      end
      M_CO: begin
        kw_want = CH_S;
        kw_fin  = 1'b1;
        kw_kind = TK_COS;
      end
      M_T: begin
        kw_want = CH_A;
        kw_next = M_TA;
      end
      M_TA: begin
        kw_want = CH_N;
        kw_fin  = 1'b1;
        kw_kind = TK_TAN;
      end
      default: kw = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    int_nxt  = int_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    consumed = 1'b0;
    a_vld    = 1'b0;
    a_kind   = TK_UNKNOWN;
    b_vld    = 1'b0;
    b_kind   = TK_UNKNOWN;

    if (kw) begin
      if (c == kw_want) begin
        consumed = 1'b1;
        if (kw_fin) begin
          a_vld    = 1'b1;
          a_kind   = kw_kind;
          mode_nxt = M_IDLE;
        end else begin
          mode_nxt = kw_next;
        end
      end else begin
        a_vld    = 1'b1;
        a_kind   = TK_UNKNOWN;
        mode_nxt = M_IDLE;
      end
    end else begin
      case (mode_r)
        M_INT, M_FRAC: begin
          if (is_dig) begin
            consumed = 1'b1;
            if (mode_r == M_INT) begin
              if (sat) begin
                int_nxt = '1;
                ov_nxt  = 1'b1;
              end else begin
                int_nxt = prod[INT_BITS-1:0];
              end
            end else if (cnt_r < FRAC_LIMIT) begin
              cnt_nxt  = cnt_inc;
              frac_nxt = frac_sum;
            end
          end else if (c == CH_DOT && mode_r == M_INT) begin
            consumed = 1'b1;
            mode_nxt = M_FRAC;
          end else begin
            a_vld    = 1'b1;
            a_kind   = TK_NUMBER;
            mode_nxt = M_IDLE;
          end
        end
        default: mode_nxt = M_IDLE;
      endcase
    end

    // A character not taken by an open token is handled as from idle.
    if (!consumed) begin
      mode_nxt = M_IDLE;
      if (is_dig) begin
        mode_nxt = M_INT;
        int_nxt  = INT_BITS'(d);
        frac_nxt = '0;
        cnt_nxt  = 4'd0;
        ov_nxt   = 1'b0;
      end else begin
        case (c)
          CH_SP, CH_TAB, CH_NL: ;
          CH_S:     mode_nxt = M_S;
          CH_C:     mode_nxt = M_C;
          CH_T:     mode_nxt = M_T;
          CH_PLUS:  begin b_vld = 1'b1; b_kind = TK_PLUS;   end
          CH_MINUS: begin b_vld = 1'b1; b_kind = TK_MINUS;  end
          CH_STAR:  begin b_vld = 1'b1; b_kind = TK_TIMES;  end
          CH_SLASH: begin b_vld = 1'b1; b_kind = TK_DIVIDE; end
          CH_LPAR:  begin b_vld = 1'b1; b_kind = TK_LPAREN; end
          CH_RPAR:  begin b_vld = 1'b1; b_kind = TK_RPAREN; end
          CH_CARET: begin b_vld = 1'b1; b_kind = TK_POWER;  end
          CH_MOD:   begin b_vld = 1'b1; b_kind = TK_MOD;    end
          CH_NUL:   begin b_vld = 1'b1; b_kind = TK_END;    end
          default:  begin b_vld = 1'b1; b_kind = TK_UNKNOWN; end
        endcase
      end
    end
  end

  assign a_num        = a_vld && a_kind == TK_NUMBER;
  assign push         = accept && (a_vld || b_vld);
  assign push_ctl.two = a_vld && b_vld;
  assign push_ctl.k0  = a_vld ? a_kind : b_kind;
  assign push_ctl.k1  = b_kind;
  assign push_ctl.ov  = a_num ? ov_r : 1'b0;
  assign push_int     = a_num ? int_r : '0;
  assign push_frac    = a_num ? frac_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  `CEL_ASSERT_IMPLY(a_num_from_scan, clk, rst_n, push && push_ctl.k0 == TK_NUMBER, mode_r == M_INT || mode_r == M_FRAC, "number token without an open number")
  `CEL_ASSERT_IMPLY(a_pair_needs_open, clk, rst_n, push && push_ctl.two, mode_r != M_IDLE, "two tokens from a word seen in idle")
  `CEL_ASSERT_IMPLY(a_second_plain, clk, rst_n, push && push_ctl.two, push_ctl.k1 != TK_NUMBER, "second token of a pair is a number")

endmodule

// ===== rtl/core/cel_tok_queue.sv =====
// Short token queue between the scanning front end and the output back end.
`include "assert_macros.svh"
module cel_tok_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import cel_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `CEL_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "write into a full token queue")
  `CEL_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty, "read from an empty token queue")
  `CEL_ASSERT_IMPLY(a_ptr_match, clk, rst_n, empty || full, wr_ptr_r == rd_ptr_r, "queue pointers disagree with the fill count")

endmodule

// ===== rtl/core/cel_back.sv =====
// Back end: splits queued token pairs and drives the registered output channel.
`include "assert_macros.svh"
module cel_back #(
  parameter int INT_BITS      = cel_pkg::INT_BITS_DEF,
  parameter int FRACTION_BITS = cel_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  cel_pkg::tok_ctl_t        head_ctl,
  input  logic [INT_BITS-1:0]      head_int,
  input  logic [FRACTION_BITS-1:0] head_frac,
  output logic                     pop,
  cel_out_if.source                out_ch
);
  import cel_pkg::*;

  logic                     out_vld_r;
  logic                     hold_r;
  tok_kind_t                hold_kind_r;
  tok_kind_t                kind_r;
  logic [INT_BITS-1:0]      int_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic                     ov_r;
  logic                     last_r;
  logic                     load;

  assign load = !out_vld_r || out_ch.ready;
  assign pop  = load && !hold_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      hold_r    <= 1'b0;
    end else if (load) begin
      if (hold_r) begin
        out_vld_r <= 1'b1;
        hold_r    <= 1'b0;
      end else begin
        out_vld_r <= !q_empty;
        hold_r    <= !q_empty && head_ctl.two;
      end
    end
  end

  // The second token of a pair is never a number, so its payload is zero.
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_r) begin
        kind_r <= hold_kind_r;
        int_r  <= '0;
        frac_r <= '0;
        ov_r   <= 1'b0;
        last_r <= 1'b1;
      end else if (!q_empty) begin
        kind_r      <= head_ctl.k0;
        int_r       <= head_int;
        frac_r      <= head_frac;
        ov_r        <= head_ctl.ov;
        last_r      <= !head_ctl.two;
        hold_kind_r <= head_ctl.k1;
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.token_kind  = kind_r;
  assign out_ch.int_part    = int_r;
  assign out_ch.frac_part   = frac_r;
  assign out_ch.overflowed  = ov_r;
  assign out_ch.last_of_run = last_r;

  `CEL_ASSERT_IMPLY(a_hold_valid, clk, rst_n, hold_r, out_vld_r && !last_r, "pending second token without a first on show")
  `CEL_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_vld_r && out_ch.ready && !last_r, out_vld_r && last_r, "second token of a pair did not follow")
  `CEL_ASSERT_IMPLY(a_plain_zero, clk, rst_n, out_vld_r && kind_r != TK_NUMBER, int_r == '0 && frac_r == '0 && !ov_r, "non-number token carries a value")

endmodule

// ===== rtl/core/calculator_expression_lexer_core.sv =====
// Expression lexer top level: one character word in, expression token words out.
//
// in_ch carries one character per word (char_code, 0 marks end of text). out_ch
// carries one token per word: token_kind, and for numbers the saturated integer
// part, the unsigned Q0.FRACTION_BITS fraction and the overflow flag. last_of_run
// marks the final token caused by one character; a character may cause none,
// one or two tokens.
// A character is taken every cycle while the token queue has room; the scanner
// does its whole update (one multiply-add on the integer or fraction) in the
// cycle the character is taken. The first token of a character goes into the
// token queue as the character is taken and then into the output register.
// A second token waits in the back end. Output runs at one token per cycle
// while out_ch.ready is high; a QUEUE_DEPTH-entry queue absorbs the difference.
// After reset the scanner is idle between tokens, the queue is empty and
// out_ch.valid is low. While the receiver holds out_ch.ready low the shown token
// stays put, the queue fills, and in_ch.ready drops once it is full.
module calculator_expression_lexer_core #(
  parameter int INT_BITS            = cel_pkg::INT_BITS_DEF,
  parameter int FRACTION_BITS       = cel_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = cel_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int QUEUE_DEPTH         = cel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cel_in_if.sink    in_ch,
  cel_out_if.source out_ch
);
  import cel_pkg::*;

  localparam int EW = $bits(tok_ctl_t) + INT_BITS + FRACTION_BITS;

  logic                     push;
  tok_ctl_t                 push_ctl;
  logic [INT_BITS-1:0]      push_int;
  logic [FRACTION_BITS-1:0] push_frac;
  logic                     pop;
  logic                     q_full;
  logic                     q_empty;
  logic [EW-1:0]            rd_data;
  tok_ctl_t                 head_ctl;
  logic [INT_BITS-1:0]      head_int;
  logic [FRACTION_BITS-1:0] head_frac;

  cel_front #(
    .INT_BITS            (INT_BITS),
    .FRACTION_BITS       (FRACTION_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_int  (push_int),
    .push_frac (push_frac)
  );

  cel_tok_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({push_ctl, push_int, push_frac}),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {head_ctl, head_int, head_frac} = rd_data;

  cel_back #(
    .INT_BITS      (INT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_ctl  (head_ctl),
    .head_int  (head_int),
    .head_frac (head_frac),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/calculator_expression_lexer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the expression lexer core: directed table, then random text.
module calculator_expression_lexer_core_tb;
  import cel_pkg::*;

  localparam int INT_W       = INT_BITS_DEF;
  localparam int FRAC_W      = FRAC_BITS_DEF;
  localparam int MAX_FD      = MAX_FRAC_DIGITS_DEF;
  localparam int RAND_CHARS  = 700;
  localparam int HOLD_CYCLES = 60;
  localparam int N_DIR       = 25;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam longint unsigned INT_SAT = (64'd1 << INT_W) - 64'd1;

  typedef enum logic [3:0] {
    SC_IDLE, SC_INT, SC_FRAC, SC_S, SC_SI, SC_C, SC_CO, SC_T, SC_TA
  } scan_state_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [INT_W-1:0]  ival;
    logic [FRAC_W-1:0] fval;
    logic              ov;
    logic              last;
  } token_t;

  // A row either carries its expected tokens (all-zero payload) or leaves them to the lexer model.
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_tok;
    tok_kind_t  kind;
  } stim_row_t;

  stim_row_t dir_rows [N_DIR] = '{
    '{" ",   1'b1, 2'd0, TK_UNKNOWN},
    '{"+",   1'b1, 2'd1, TK_PLUS},
    '{"-",   1'b1, 2'd1, TK_MINUS},
    '{"*",   1'b1, 2'd1, TK_TIMES},
    '{"/",   1'b1, 2'd1, TK_DIVIDE},
    '{"^",   1'b1, 2'd1, TK_POWER},
    '{"%",   1'b1, 2'd1, TK_MOD},
    '{"(",   1'b1, 2'd1, TK_LPAREN},
    '{")",   1'b1, 2'd1, TK_RPAREN},
    '{8'hFF, 1'b1, 2'd1, TK_UNKNOWN},
    '{"s",   1'b0, 2'd0, TK_UNKNOWN},
    '{"i",   1'b0, 2'd0, TK_UNKNOWN},
    '{"n",   1'b1, 2'd1, TK_SIN},
    '{"c",   1'b0, 2'd0, TK_UNKNOWN},
    '{"o",   1'b0, 2'd0, TK_UNKNOWN},
    '{"s",   1'b1, 2'd1, TK_COS},
    '{"t",   1'b0, 2'd0, TK_UNKNOWN},
    '{"a",   1'b0, 2'd0, TK_UNKNOWN},
    '{"n",   1'b1, 2'd1, TK_TAN},
    '{"7",   1'b0, 2'd0, TK_UNKNOWN},
    '{".",   1'b0, 2'd0, TK_UNKNOWN},
    '{".",   1'b0, 2'd0, TK_UNKNOWN},
    '{"s",   1'b0, 2'd0, TK_UNKNOWN},
    '{CH_NUL, 1'b0, 2'd0, TK_UNKNOWN},
    '{CH_NUL, 1'b1, 2'd1, TK_END}
  };

  logic clk = 1'b0;
  logic rst_n;

  cel_in_if in_ch ();
  cel_out_if #(.INT_BITS(INT_W), .FRACTION_BITS(FRAC_W)) out_ch ();

  calculator_expression_lexer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #4 clk = ~clk;

  // Lexer model state, idle after reset.
  scan_state_t       mode      = SC_IDLE;
  logic [INT_W-1:0]  int_acc   = '0;
  logic [FRAC_W-1:0] frac_acc  = '0;
  logic [3:0]        frac_cnt  = '0;
  logic              sat_seen  = 1'b0;

  token_t     step_toks [$];
  token_t     token_q [$];
  stim_row_t  row_q [$];
  logic [7:0] burst [$];

  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int errors   = 0;
  int n_chars  = 0;
  int n_tokens = 0;
  int n_nums   = 0;
  int n_sat    = 0;
  int n_holds  = 0;

  function automatic longint unsigned frac_weight(input int unsigned k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return (64'd1 << FRAC_W) / p;
  endfunction

  function automatic void add_token(input tok_kind_t k, input logic [INT_W-1:0] iv,
                                    input logic [FRAC_W-1:0] fv, input logic ov);
    token_t t;
    t.kind = k;
    t.ival = iv;
    t.fval = fv;
    t.ov   = ov;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void lex_idle(input logic [7:0] c);
    if (c == " " || c == CH_TAB || c == CH_LF) return;
    if (c >= "0" && c <= "9") begin
      mode     = SC_INT;
      int_acc  = INT_W'(c - "0");
      frac_acc = '0;
      frac_cnt = '0;
      sat_seen = 1'b0;
      return;
    end
    case (c)
      "+":     add_token(TK_PLUS, '0, '0, 1'b0);
      "-":     add_token(TK_MINUS, '0, '0, 1'b0);
      "*":     add_token(TK_TIMES, '0, '0, 1'b0);
      "/":     add_token(TK_DIVIDE, '0, '0, 1'b0);
      "(":     add_token(TK_LPAREN, '0, '0, 1'b0);
      ")":     add_token(TK_RPAREN, '0, '0, 1'b0);
      "^":     add_token(TK_POWER, '0, '0, 1'b0);
      "%":     add_token(TK_MOD, '0, '0, 1'b0);
      CH_NUL:  add_token(TK_END, '0, '0, 1'b0);
      "s":     mode = SC_S;
      "c":     mode = SC_C;
      "t":     mode = SC_T;
      default: add_token(TK_UNKNOWN, '0, '0, 1'b0);
    endcase
  endfunction

  // Returns 1 when the keyword swallowed the character.
  function automatic bit keyword_char(input logic [7:0] c, input logic [7:0] want,
                                      input scan_state_t nxt, input tok_kind_t done);
    if (c == want) begin
      if (done != TK_UNKNOWN) begin
        add_token(done, '0, '0, 1'b0);
        mode = SC_IDLE;
      end else begin
        mode = nxt;
      end
      return 1'b1;
    end
    add_token(TK_UNKNOWN, '0, '0, 1'b0);
    mode = SC_IDLE;
    return 1'b0;
  endfunction

  // Works out the tokens one character gives and leaves them in step_toks.
  function automatic void lex_char(input logic [7:0] c);
    bit              taken;
    longint unsigned d;
    longint unsigned sum;
    taken = 1'b0;
    step_toks.delete();
    case (mode)
      SC_INT, SC_FRAC: begin
        if (c >= "0" && c <= "9") begin
          d = 64'(c - "0");
          if (mode == SC_INT) begin
            if (64'(int_acc) > (INT_SAT - d) / 10) begin
              int_acc  = '1;
              sat_seen = 1'b1;
            end else begin
              int_acc = INT_W'(64'(int_acc) * 10 + d);
            end
          end else if (frac_cnt < MAX_FD && frac_cnt < 9) begin
            frac_cnt = frac_cnt + 4'd1;
            sum      = 64'(frac_acc) + d * frac_weight(frac_cnt);
            frac_acc = sum[FRAC_W-1:0];
          end
          taken = 1'b1;
        end else if (c == "." && mode == SC_INT) begin
          mode  = SC_FRAC;
          taken = 1'b1;
        end else begin
          add_token(TK_NUMBER, int_acc, frac_acc, sat_seen);
          mode = SC_IDLE;
        end
      end
      SC_S:    taken = keyword_char(c, "i", SC_SI, TK_UNKNOWN);
      SC_SI:   taken = keyword_char(c, "n", SC_IDLE, TK_SIN);
      SC_C:    taken = keyword_char(c, "o", SC_CO, TK_UNKNOWN);
      SC_CO:   taken = keyword_char(c, "s", SC_IDLE, TK_COS);
      SC_T:    taken = keyword_char(c, "a", SC_TA, TK_UNKNOWN);
      SC_TA:   taken = keyword_char(c, "n", SC_IDLE, TK_TAN);
      default: mode = SC_IDLE;
    endcase
    if (!taken) lex_idle(c);
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  // Appends one random stretch of text: mostly well-formed tokens, some noise.
  function automatic void queue_text();
    string ops;
    string seps;
    string kw;
    string digits;
    int    r;
    int    nd;
    ops  = "+-*/^%()";
    seps = " \t\n";
    r    = $urandom_range(99);
    if (r < 40) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       digits = "4294967295";
          1:       digits = "4294967296";
          2:       digits = "99999999999999";
          default: digits = "0.99999999999";
        endcase
        foreach (digits[i]) burst.push_back(digits[i]);
      end else begin
        nd = ($urandom_range(3) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
        repeat (nd) burst.push_back(8'("0" + $urandom_range(9)));
        if ($urandom_range(1) == 1) begin
          burst.push_back(".");
          repeat ($urandom_range(11)) burst.push_back(8'("0" + $urandom_range(9)));
        end
      end
    end else if (r < 58) begin
      burst.push_back(ops[$urandom_range(7)]);
    end else if (r < 72) begin
      case ($urandom_range(2))
        0:       kw = "sin";
        1:       kw = "cos";
        default: kw = "tan";
      endcase
      if ($urandom_range(3) == 0) begin
        nd = $urandom_range(2, 1);
        for (int i = 0; i < nd; i++) burst.push_back(kw[i]);
        burst.push_back(8'($urandom_range(255)));
      end else begin
        foreach (kw[i]) burst.push_back(kw[i]);
      end
    end else if (r < 82) begin
      repeat ($urandom_range(3, 1)) burst.push_back(seps[$urandom_range(2)]);
    end else if (r < 87) begin
      burst.push_back(CH_NUL);
    end else begin
      burst.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_item(input stim_row_t row);
    row_q.push_back(row);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= row.ch;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : monitor
    stim_row_t row;
    token_t    t;
    token_t    want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        row = row_q.pop_front();
        lex_char(in_ch.char_code);
        n_chars++;
        if (row.typed) begin
          for (int i = 0; i < row.n_tok; i++) begin
            t.kind = row.kind;
            t.ival = '0;
            t.fval = '0;
            t.ov   = 1'b0;
            t.last = (i == row.n_tok - 1);
            token_q.push_back(t);
          end
        end else begin
          foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        n_tokens++;
        if (out_ch.token_kind == TK_NUMBER) n_nums++;
        if (out_ch.overflowed) n_sat++;
        if (token_q.size() == 0) begin
          errors++;
          $display("%0t: token word with none expected: kind %0d int %0d frac %h",
                   $time, out_ch.token_kind, out_ch.int_part, out_ch.frac_part);
        end else begin
          want = token_q.pop_front();
          if (out_ch.token_kind !== want.kind || out_ch.int_part !== want.ival ||
              out_ch.frac_part !== want.fval || out_ch.overflowed !== want.ov ||
              out_ch.last_of_run !== want.last) begin
            errors++;
            $display("%0t: expected kind %0d int %0d frac %h ov %b last %b, got %0d %0d %h %b %b",
                     $time, want.kind, want.ival, want.fval, want.ov, want.last,
                     out_ch.token_kind, out_ch.int_part, out_ch.frac_part,
                     out_ch.overflowed, out_ch.last_of_run);
          end
        end
      end
    end
  end

  // The receiver; a hold-off keeps ready low long enough for the token queue to fill.
  initial begin : receiver
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= !(gaps_on && $urandom_range(99) < 36);
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    logic [7:0] c;
    int         n_random;
    int         holds_asked;
    in_ch.valid     = 1'b0;
    in_ch.char_code = CH_NUL;
    rst_n           = 1'b0;
    n_random        = 0;
    holds_asked     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < N_DIR; k++) send_item(dir_rows[k]);

    // The first stretch of random text runs with no idling on either side.
    gaps_on = 1'b0;
    row     = '{CH_NUL, 1'b0, 2'd0, TK_UNKNOWN};
    while (n_random < RAND_CHARS) begin
      if (n_random >= 200) gaps_on = 1'b1;
      if (holds_asked < 2 && n_random >= 250 + 250 * holds_asked) begin
        hold_req = 1'b1;
        holds_asked++;
      end
      queue_text();
      while (burst.size() > 0) begin
        c      = burst.pop_front();
        row.ch = c;
        send_item(row);
        if (!(c == " " || c == CH_TAB || c == CH_LF)) n_random++;
      end
    end
    // A closing end of text flushes any open token.
    row.ch = CH_NUL;
    send_item(row);
    in_ch.valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (token_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected tokens never arrived", $time, token_q.size());
    end
    $display("Lexed %0d characters into %0d tokens, %0d of them numbers (%0d saturated).",
             n_chars, n_tokens, n_nums, n_sat);
    $display("Receiver held off %0d times; %0d mismatches found.", n_holds, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule
